// File: src/lphm_pkg.sv
// Package for the linear-probe hash map: sizes, codes, shared types.
// No dependencies; imported by lphm_key_store and linear_probe_hash_map.
package lphm_pkg;

  // Table geometry. SLOTS must be a power of two: the home slot is the
  // low bits of the key hash.
  localparam int unsigned SLOTS   = 16;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = $clog2(SLOTS + 1);

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_ZERO_KEY = 2'd3;

  // Command to the key store: one address, read or write.
  typedef struct packed {
    logic  rd;
    logic  wr;
    slot_t addr;
    key_t  wdata;
  } key_cmd_t;

endpackage

// File: src/lphm_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module lphm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/lphm_key_store.sv
// Key store: SLOTS x 64-bit keys with per-slot valid bits so reset empties it.
// Depends on lphm_pkg.
module lphm_key_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lphm_pkg::key_cmd_t cmd_i,
  output lphm_pkg::key_t     rdata_o
);
  import lphm_pkg::*;

  key_t             mem_q [SLOTS];
  logic [SLOTS-1:0] valid_q;
  key_t             rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[cmd_i.addr] <= cmd_i.wdata;
    end
    if (cmd_i.rd) begin
      // never-written slot reads as empty
      rdata_q <= valid_q[cmd_i.addr] ? mem_q[cmd_i.addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.wr) begin
      valid_q[cmd_i.addr] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/linear_probe_hash_map.sv
// Linear-probe hash map top level: control sequencer, count, result register.
// Depends on lphm_pkg, lphm_key_store, lphm_ram.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | into      | in_valid_i / in_ready_o | opcode_i, key_hash_i, value_in_i
//  out     | out of    | out_valid_o/out_ready_i | status_o, value_out_o, slot_pos_o,
//          |           |                        | entry_total_o
//
// Steps: a request is accepted, then probes 1 to SLOTS slots, one slot per cycle
// through the single key store read port, then reads the value on a lookup hit,
// then loads the result register. Zero keys and the unused opcode skip the probe.
// Reset: asynchronous, active low; empties every slot at once through the key
// store's valid bits, so no clearing pass is needed. The value store is not reset.
// Stalls: a new request is taken while a finished result waits in the output
// register; a second result waits in the done state until the output frees up.
module linear_probe_hash_map (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  lphm_pkg::key_t        key_hash_i,
  input  lphm_pkg::value_t      value_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output lphm_pkg::value_t      value_out_o,
  output lphm_pkg::slot_t       slot_pos_o,
  output lphm_pkg::count_t      entry_total_o
);
  import lphm_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a request
  localparam logic [1:0] S_PROBE = 2'd1;  // key of slot_q is on the read port
  localparam logic [1:0] S_VALUE = 2'd2;  // value of the hit is on the read port
  localparam logic [1:0] S_DONE  = 2'd3;  // result ready for the output register

  logic [1:0] state_q, state_d;

  // Request being worked on
  logic [1:0] op_q, op_d;
  key_t       key_q, key_d;
  value_t     val_q, val_d;
  slot_t      slot_q, slot_d;   // slot whose key is being evaluated
  slot_t      step_q, step_d;   // probes done so far, minus one

  count_t     count_q, count_d;

  // Pending result
  logic [1:0] res_status_q, res_status_d;
  value_t     res_value_q, res_value_d;
  slot_t      res_slot_q, res_slot_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_status_q, out_status_d;
  value_t     out_value_q, out_value_d;
  slot_t      out_slot_q, out_slot_d;
  count_t     out_total_q, out_total_d;

  // Memory ports
  key_cmd_t   key_cmd;
  key_t       key_rdata;
  logic       val_we, val_re;
  value_t     val_rdata;

  logic       accept;
  logic       out_free;
  logic       slot_empty, slot_match, last_probe;
  slot_t      slot_next;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  assign slot_empty = (key_rdata == '0);
  assign slot_match = (key_rdata == key_q);
  assign last_probe = (step_q == slot_t'(SLOTS - 1));
  assign slot_next  = slot_q + slot_t'(1);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    val_d        = val_q;
    slot_d       = slot_q;
    step_d       = step_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_slot_d   = out_slot_q;
    out_total_d  = out_total_q;

    key_cmd       = '0;
    key_cmd.addr  = slot_q;
    key_cmd.wdata = key_q;
    val_we        = 1'b0;
    val_re        = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d         = opcode_i;
          key_d        = key_hash_i;
          val_d        = value_in_i;
          slot_d       = key_hash_i[SLOT_W-1:0];  // home slot
          step_d       = '0;
          res_value_d  = '0;
          res_slot_d   = '0;
          res_status_d = ST_NOTFOUND;
          if (key_hash_i == '0) begin
            res_status_d = ST_ZERO_KEY;
            state_d      = S_DONE;
          end else if (opcode_i inside {OP_INSERT, OP_LOOKUP, OP_REMOVE}) begin
            key_cmd.rd   = 1'b1;
            key_cmd.addr = key_hash_i[SLOT_W-1:0];
            state_d      = S_PROBE;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_PROBE: begin
        case (op_q)
          OP_INSERT: begin
            if (slot_empty || slot_match) begin
              key_cmd.wr   = 1'b1;
              val_we       = 1'b1;
              if (slot_empty) begin
                count_d = count_q + count_t'(1);
              end
              res_status_d = ST_OK;
              res_slot_d   = slot_q;
              state_d      = S_DONE;
            end else if (last_probe) begin
              res_status_d = ST_FULL;
              state_d      = S_DONE;
            end
          end
          OP_LOOKUP: begin
            if (slot_match) begin
              val_re       = 1'b1;
              res_status_d = ST_OK;
              res_slot_d   = slot_q;
              state_d      = S_VALUE;
            end else if (slot_empty || last_probe) begin
              state_d = S_DONE;
            end
          end
          OP_REMOVE: begin
            if (slot_match) begin
              key_cmd.wr    = 1'b1;
              key_cmd.wdata = '0;
              if (count_q != '0) begin
                count_d = count_q - count_t'(1);
              end
              res_status_d = ST_OK;
              res_slot_d   = slot_q;
              state_d      = S_DONE;
            end else if (last_probe) begin
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
        // keep walking: fetch the next slot's key
        if (state_d == S_PROBE) begin
          key_cmd.rd   = 1'b1;
          key_cmd.addr = slot_next;
          slot_d       = slot_next;
          step_d       = step_q + slot_t'(1);
        end
      end

      S_VALUE: begin
        res_value_d = val_rdata;
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_slot_d   = res_slot_q;
          out_total_d  = count_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    val_q        <= val_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_slot_q   <= out_slot_d;
    out_total_q  <= out_total_d;
  end

  lphm_key_store u_key_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (key_cmd),
    .rdata_o (key_rdata)
  );

  lphm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (SLOTS)
  ) u_value_store (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (slot_q),
    .wdata_i (val_q),
    .re_i    (val_re),
    .raddr_i (slot_q),
    .rdata_o (val_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign value_out_o   = out_value_q;
  assign slot_pos_o    = out_slot_q;
  assign entry_total_o = out_total_q;

`ifndef SYNTHESIS
  // Occupancy can never exceed the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= count_t'(SLOTS))
    else $error("entry count above table size");

  // The key store is never read and written in the same cycle.
  a_key_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(key_cmd.rd && key_cmd.wr))
    else $error("key store read and write collide");

  // Every walk starts at the first probe.
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> step_q == '0)
    else $error("probe counter not cleared at request start");

  // A failed request reports slot zero and no value.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (slot_pos_o == '0 && value_out_o == '0))
    else $error("failed request carries a slot or value");
`endif

endmodule
